// ----- sv/assert_macros.svh -----
// Assertion macros shared by the scheduler modules.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- sv/njs_pkg.sv -----
// Shared types and constants for the non-preemptive job scheduler.
// No dependencies.
package njs_pkg;
    // Job table depth; the 5-bit job index and the sum widths are sized for it.
    localparam int MAX_JOBS = 32;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;

    localparam logic [1:0] KIND_JOB     = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_IDLE   = 1'b1;

    localparam logic [15:0] IDLE_LIMIT_RESET = 16'd100;
    localparam logic [23:0] SAT24 = 24'hFFFFFF;

    typedef struct packed {
        logic [9:0] arrival_time;
        logic [9:0] run_time;
        logic [7:0] job_priority;
        logic       last_job;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [4:0]  job_index;
        logic [15:0] start_time;
        logic [15:0] finish_time;
        logic [15:0] turnaround;
        logic [23:0] weighted_turnaround;
        logic [23:0] average_turnaround;
        logic [23:0] average_weighted;
        logic        last_result;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;        // write the input beat into the table
        logic scan_start;   // begin a selection scan
        logic scan_step;    // examine one table entry
        logic commit_job;   // compute start/finish/turnaround for the pick
        logic div_start;    // launch the serial divider
        logic job_done;     // accumulate sums and set done flag
        logic tick;         // advance time one idle tick
        logic avg_sel_w;    // 0: average turnaround, 1: average weighted
        logic clear;        // reset run state
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;    // current scan index is the last stored entry
        logic found;        // scan picked an eligible job
        logic div_busy;
        logic timeout;      // time is above the idle limit
        logic all_done;
        logic empty;
    } t_sts;
endpackage

// ----- sv/nonpreemptive_job_scheduler.sv -----
// Top level of the non-preemptive job scheduler: config registers and wiring.
// Depends on njs_pkg, njs_ctrl and njs_datapath.
//
// Jobs load one per beat; the beat with last_job set starts a run. Each
// scheduled job costs one scan over all N loaded jobs, a start of the serial
// divide, a wait on it and an emit of its record. Each idle tick costs a
// full scan, and the summary takes two more divides before its beat. A
// stalled result beat holds the controller until it is taken. Input is
// stalled for the whole run.
module nonpreemptive_job_scheduler
    import njs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic      o_cfg_ready
);
    logic [1:0]  r_policy;
    logic [15:0] r_idle;
    t_cmd        w_cmd;
    t_sts        w_sts;
    t_out_item   w_job_rec, w_end_rec;
    logic [23:0] w_div_q;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FCFS;
            r_idle   <= IDLE_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POLICY: r_policy <= i_cfg_data[1:0];
                CFG_IDLE:   r_idle   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    njs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts),
        .i_job_rec   (w_job_rec),
        .i_end_rec   (w_end_rec),
        .i_div_q     (w_div_q)
    );

    njs_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_item       (i_in_data),
        .i_policy     (r_policy),
        .i_idle_limit (r_idle),
        .o_sts        (w_sts),
        .o_job_rec    (w_job_rec),
        .o_end_rec    (w_end_rec),
        .o_div_q      (w_div_q)
    );
endmodule

// ----- sv/njs_div.sv -----
// Restoring serial divider: one quotient bit per cycle.
// Depends on njs_pkg (for saturation constant).
module njs_div
    import njs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [28:0] i_num,
    input  logic [9:0]  i_den,
    output logic        o_busy,
    output logic [23:0] o_quot
);
    logic [28:0] r_q;
    logic [10:0] r_rem;
    logic [4:0]  r_cnt;
    logic [9:0]  r_den;
    logic        r_busy;
    logic [10:0] w_trial;
    logic [11:0] w_diff;

    // Shift in the next numerator bit and try a subtract.
    assign w_trial = {r_rem[9:0], r_q[28]};
    assign w_diff  = {1'b0, w_trial} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd28;
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_diff[11]) begin
                r_rem <= w_diff[10:0];
                r_q   <= {r_q[27:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q   <= {r_q[27:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    // A zero divisor or a quotient over 24 bits saturates.
    assign o_quot = (r_den == 10'd0 || r_q[28:24] != 5'd0) ? SAT24 : r_q[23:0];
endmodule

// ----- sv/njs_datapath.sv -----
// Scheduler datapath: job table, scan, time, sums and result formation.
// Depends on njs_pkg and njs_div.
`include "assert_macros.svh"
module njs_datapath
    import njs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_in_item    i_item,
    input  logic [1:0]  i_policy,
    input  logic [15:0] i_idle_limit,
    output t_sts        o_sts,
    output t_out_item   o_job_rec,
    output t_out_item   o_end_rec,
    output logic [23:0] o_div_q
);
    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);

    logic [27:0]         r_table [MAX_JOBS];
    logic [MAX_JOBS-1:0] r_done;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_ndone;
    logic [15:0]         r_time;
    logic [20:0]         r_ta_sum;
    logic [28:0]         r_w_sum;
    logic [IW-1:0]       r_idx;
    logic [27:0]         r_rd;
    logic                r_rd_ok;
    logic [IW-1:0]       r_rd_idx;
    logic                r_found;
    logic [IW-1:0]       r_best;
    logic [27:0]         r_best_rec;
    logic [15:0]         r_start;
    logic [15:0]         r_finish;
    logic [15:0]         r_ta;
    logic [9:0]          r_run;
    logic                w_better;
    logic                w_elig;
    logic [9:0]          c_arr, b_arr, c_run, b_run;
    logic [7:0]          c_pri, b_pri;
    logic [28:0]         w_num;
    logic [9:0]          w_den;

    // Table write on load and registered table read during the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && r_count < CW'(MAX_JOBS)) begin
            r_table[r_count[IW-1:0]] <= {i_item.arrival_time, i_item.run_time,
                                         i_item.job_priority};
        end
        r_rd     <= r_table[r_idx];
        r_rd_idx <= r_idx;
    end

    assign {c_arr, c_run, c_pri} = r_rd;
    assign {b_arr, b_run, b_pri} = r_best_rec;
    assign w_elig = r_rd_ok && !r_done[r_rd_idx] && ({6'd0, c_arr} <= r_time);

    // Policy comparison of the entry just read against the current pick.
    always_comb begin
        case (i_policy)
            POL_SJF:  w_better = c_run < b_run || (c_run == b_run && c_pri > b_pri);
            POL_PRIO: w_better = c_pri > b_pri;
            default:  w_better = c_arr < b_arr || (c_arr == b_arr && c_pri > b_pri);
        endcase
    end

    // Scan, commit and run bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_done   <= '0;
            r_count  <= '0;
            r_ndone  <= '0;
            r_time   <= '0;
            r_ta_sum <= '0;
            r_w_sum  <= '0;
            r_idx    <= '0;
            r_rd_ok  <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_cmd.store && r_count < CW'(MAX_JOBS)) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.scan_start) begin
                r_idx   <= '0;
                r_rd_ok <= 1'b0;
                r_found <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_ok <= 1'b1;
                if (!o_sts.scan_last) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (w_elig && (!r_found || w_better)) begin
                    r_found    <= 1'b1;
                    r_best     <= r_rd_idx;
                    r_best_rec <= r_rd;
                end
            end
            if (i_cmd.commit_job) begin
                r_start  <= r_time;
                r_finish <= r_time + {6'd0, b_run};
                r_ta     <= r_time + {6'd0, b_run} - {6'd0, b_arr};
                r_run    <= b_run;
            end
            if (i_cmd.job_done) begin
                r_time   <= r_finish;
                r_ta_sum <= r_ta_sum + {5'd0, r_ta};
                r_w_sum  <= r_w_sum + {5'd0, o_div_q};
                r_done[r_best] <= 1'b1;
                r_ndone  <= r_ndone + CW'(1);
            end
            if (i_cmd.tick) begin
                r_time <= r_time + 16'd1;
            end
        end
    end

    // Divider operands: weighted turnaround or one of the averages.
    always_comb begin
        if (i_cmd.avg_sel_w) begin
            w_num = r_w_sum;
            w_den = 10'(r_count);
        end else if (o_sts.all_done) begin
            w_num = {r_ta_sum, 8'd0};
            w_den = 10'(r_count);
        end else begin
            w_num = {5'd0, r_ta, 8'd0};
            w_den = r_run;
        end
    end

    njs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (o_sts.div_busy),
        .o_quot  (o_div_q)
    );

    // The scan ends on the registered read data of the last address, not on the address itself.
    assign o_sts.scan_last = r_rd_ok && ({{(CW-IW){1'b0}}, r_rd_idx} + CW'(1) >= r_count);
    assign o_sts.found     = r_found;
    assign o_sts.timeout   = r_time > i_idle_limit;
    assign o_sts.all_done  = r_ndone == r_count;
    assign o_sts.empty     = r_count == '0;

    always_comb begin
        o_job_rec = '0;
        o_job_rec.record_kind         = KIND_JOB;
        o_job_rec.job_index           = 5'(r_best);
        o_job_rec.start_time          = r_start;
        o_job_rec.finish_time         = r_finish;
        o_job_rec.turnaround          = r_ta;
        o_job_rec.weighted_turnaround = o_div_q;
        o_end_rec = '0;
        o_end_rec.finish_time         = r_time;
        o_end_rec.last_result         = 1'b1;
    end

    `ASSERT_IMPL(a_done_le_count, i_clk, i_rst_n, 1'b1, r_ndone <= r_count)
    `ASSERT_NEXT(a_done_sets, i_clk, i_rst_n, i_cmd.job_done && !i_cmd.clear, r_done[$past(r_best)])
endmodule

// ----- sv/njs_ctrl.sv -----
// Scheduler controller: load, scan, divide, emit and summarize sequencing.
// Depends on njs_pkg.
`include "assert_macros.svh"
module njs_ctrl
    import njs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    output logic        o_in_stall,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_data,
    output t_cmd        o_cmd,
    input  t_sts        i_sts,
    input  t_out_item   i_job_rec,
    input  t_out_item   i_end_rec,
    input  logic [23:0] i_div_q
);
    typedef enum logic [3:0] {
        S_LOAD, S_SCAN0, S_SCAN, S_DECIDE, S_DIV, S_DIVW, S_EMIT,
        S_AVG_T, S_AVG_TW, S_AVG_W, S_AVG_WW, S_END, S_WAIT
    } t_state;

    t_state      r_state, n_state;
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;
    logic [23:0] r_avg_t;
    logic        w_in_acc, w_out_free;
    logic        w_emit;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_LOAD);
    assign w_emit     = (r_state == S_EMIT || r_state == S_END) && w_out_free;

    // Command decode.
    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                o_cmd.store = w_in_acc;
                if (w_in_acc && i_in_data.last_job) begin
                    n_state = S_SCAN0;
                end
            end
            S_SCAN0: begin
                o_cmd.scan_start = 1'b1;
                n_state = i_sts.all_done ? S_AVG_T : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.found) begin
                    o_cmd.commit_job = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.tick = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: n_state = i_sts.timeout ? S_END : S_SCAN0;
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIVW;
            end
            S_DIVW: if (!i_sts.div_busy) n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.job_done = 1'b1;
                    n_state = S_SCAN0;
                end
            end
            S_AVG_T: begin
                o_cmd.div_start = !i_sts.empty;
                n_state = S_AVG_TW;
            end
            S_AVG_TW: if (!i_sts.div_busy) n_state = S_AVG_W;
            S_AVG_W: begin
                o_cmd.avg_sel_w = 1'b1;
                o_cmd.div_start = !i_sts.empty;
                n_state = S_AVG_WW;
            end
            S_AVG_WW: begin
                o_cmd.avg_sel_w = 1'b1;
                if (!i_sts.div_busy) n_state = S_END;
            end
            S_END: begin
                if (w_out_free) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Next result beat: a job record, or the closing summary or timeout record.
    always_comb begin
        n_out = i_job_rec;
        if (r_state == S_END) begin
            n_out = i_end_rec;
            if (i_sts.timeout && !i_sts.all_done) begin
                n_out.record_kind = KIND_TIMEOUT;
            end else begin
                n_out.record_kind        = KIND_SUMMARY;
                n_out.average_turnaround = r_avg_t;
                n_out.average_weighted   = i_sts.empty ? 24'd0 : i_div_q;
            end
        end
    end

    // State and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_AVG_TW && !i_sts.div_busy) begin
                r_avg_t <= i_sts.empty ? 24'd0 : i_div_q;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)
    `ASSERT_IMPL(a_load_only, i_clk, i_rst_n, o_cmd.store, r_state == S_LOAD)
endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the non-preemptive job scheduler.
// Depends on njs_pkg and nonpreemptive_job_scheduler; predicts every record in-line.
module tb_top;
    import njs_pkg::*;

    localparam int TABLE_DEPTH = MAX_JOBS;
    localparam int CYCLE_LIMIT = 20000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    t_in_item    i_in_data;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic        i_out_stall;
    logic        i_cfg_valid;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_cfg_ready;

    nonpreemptive_job_scheduler dut (.*);

    // Clock with a 10 unit period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Scheduler state as the testbench sees it.
    logic [9:0]  job_arr [TABLE_DEPTH];
    logic [9:0]  job_run [TABLE_DEPTH];
    logic [7:0]  job_pri [TABLE_DEPTH];
    int          jobs_loaded;
    logic [1:0]  sched_policy;
    logic [15:0] idle_limit;
    t_out_item   sched_records[$];
    int          fail_count;
    int          cycle_count;
    bit          quiet_sink;

    function automatic bit beats_pick(int c, int b);
        if (sched_policy == POL_SJF)
            return job_run[c] < job_run[b] ||
                   (job_run[c] == job_run[b] && job_pri[c] > job_pri[b]);
        if (sched_policy == POL_PRIO)
            return job_pri[c] > job_pri[b];
        return job_arr[c] < job_arr[b] ||
               (job_arr[c] == job_arr[b] && job_pri[c] > job_pri[b]);
    endfunction

    function automatic logic [23:0] sat24(longint unsigned v);
        return (v > SAT24) ? SAT24 : v[23:0];
    endfunction

    // Predict the records that one accepted job beat causes.
    function automatic void schedule_predict(t_in_item it);
        bit [TABLE_DEPTH-1:0] finished;
        int               done_n, pick;
        longint unsigned  now, ta, wt, ta_sum, wt_sum;
        t_out_item        rec;
        finished = '0;
        done_n = 0;
        now = 0;
        ta_sum = 0;
        wt_sum = 0;
        if (jobs_loaded < TABLE_DEPTH) begin
            job_arr[jobs_loaded] = it.arrival_time;
            job_run[jobs_loaded] = it.run_time;
            job_pri[jobs_loaded] = it.job_priority;
            jobs_loaded++;
        end
        if (!it.last_job) return;
        while (done_n < jobs_loaded) begin
            pick = -1;
            for (int i = 0; i < jobs_loaded; i++) begin
                if (!finished[i] && job_arr[i] <= now)
                    if (pick < 0 || beats_pick(i, pick)) pick = i;
            end
            if (pick < 0) begin
                now++;
                if (now > idle_limit) begin
                    rec = '0;
                    rec.record_kind = KIND_TIMEOUT;
                    rec.finish_time = now[15:0];
                    rec.last_result = 1'b1;
                    sched_records.push_back(rec);
                    jobs_loaded = 0;
                    return;
                end
                continue;
            end
            rec = '0;
            rec.record_kind = KIND_JOB;
            rec.job_index = pick[4:0];
            rec.start_time = now[15:0];
            now += job_run[pick];
            ta = now - job_arr[pick];
            wt = (job_run[pick] != 0) ? sat24((ta << 8) / job_run[pick]) : SAT24;
            ta_sum += ta;
            wt_sum += wt;
            rec.finish_time = now[15:0];
            rec.turnaround = ta[15:0];
            rec.weighted_turnaround = wt[23:0];
            finished[pick] = 1'b1;
            done_n++;
            sched_records.push_back(rec);
        end
        rec = '0;
        rec.record_kind = KIND_SUMMARY;
        rec.finish_time = now[15:0];
        if (jobs_loaded > 0) begin
            rec.average_turnaround = sat24((ta_sum << 8) / jobs_loaded);
            rec.average_weighted = sat24(wt_sum / jobs_loaded);
        end
        rec.last_result = 1'b1;
        sched_records.push_back(rec);
        jobs_loaded = 0;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each accepted result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sched_records.size() == 0) begin
                $error("unexpected result beat, kind %0d", o_out_data.record_kind);
                fail_count++;
            end else begin
                want = sched_records.pop_front();
                check_field("record_kind", want.record_kind, o_out_data.record_kind);
                check_field("job_index", want.job_index, o_out_data.job_index);
                check_field("start_time", want.start_time, o_out_data.start_time);
                check_field("finish_time", want.finish_time, o_out_data.finish_time);
                check_field("turnaround", want.turnaround, o_out_data.turnaround);
                check_field("weighted_turnaround", want.weighted_turnaround,
                            o_out_data.weighted_turnaround);
                check_field("average_turnaround", want.average_turnaround,
                            o_out_data.average_turnaround);
                check_field("average_weighted", want.average_weighted,
                            o_out_data.average_weighted);
                check_field("last_result", want.last_result, o_out_data.last_result);
            end
        end
    end

    // Result-side back-pressure: mostly short stalls, now and then a long one.
    int stall_left;
    always @(posedge i_clk) begin
        int r;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (quiet_sink) begin
            i_out_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 19);
            i_out_stall <= (r < 5);
            if (r == 0) stall_left <= $urandom_range(10, 60);
            else if (r < 5) stall_left <= $urandom_range(0, 3);
        end
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 19) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one job beat and hold it until the scheduler takes it.
    task automatic send_job(logic [9:0] arr, logic [9:0] run, logic [7:0] pri,
                            logic last, bit gaps = 1);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data <= '{arrival_time: arr, run_time: run, job_priority: pri,
                       last_job: last};
        do @(posedge i_clk); while (o_in_stall);
        schedule_predict('{arrival_time: arr, run_time: run, job_priority: pri,
                           last_job: last});
        gap = gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sched_records.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_POLICY) sched_policy = val[1:0];
        else idle_limit = val;
    endtask

    // Field extremes with the largest idle limit: zero and maximum arrival, priority 0/255.
    task automatic test_extremes();
        write_reg(CFG_IDLE, 16'hFFFF);
        send_job(10'd0, 10'd1023, 8'd0, 1'b0);
        send_job(10'd1023, 10'd1, 8'd255, 1'b0);
        send_job(10'h2AA, 10'h155, 8'hAA, 1'b0);
        send_job(10'h155, 10'h2AA, 8'h55, 1'b1);
        drain();
    endtask

    // Each policy code, the unused one included, on a set with ties.
    task automatic test_policies();
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_POLICY, 16'(p));
            send_job(10'd0, 10'd5, 8'd3, 1'b0);
            send_job(10'd0, 10'd5, 8'd9, 1'b0);
            send_job(10'd2, 10'd2, 8'd9, 1'b0);
            send_job(10'd1, 10'd8, 8'd200, 1'b0);
            send_job(10'd2, 10'd2, 8'd9, 1'b1);
            drain();
        end
    endtask

    // Idle timeout, a zero idle limit, and a job of zero run time.
    task automatic test_timeout_and_zero_run();
        write_reg(CFG_POLICY, {14'd0, POL_FCFS});
        write_reg(CFG_IDLE, 16'd100);
        send_job(10'd300, 10'd4, 8'd1, 1'b1);
        drain();
        write_reg(CFG_IDLE, 16'd0);
        send_job(10'd1, 10'd4, 8'd1, 1'b1);
        drain();
        write_reg(CFG_IDLE, 16'd50);
        send_job(10'd0, 10'd0, 8'd7, 1'b0);
        send_job(10'd3, 10'd6, 8'd7, 1'b1);
        drain();
    endtask

    // More records than the table holds; the dropped last record starts the run.
    task automatic test_table_full();
        quiet_sink = 1'b1;
        write_reg(CFG_POLICY, {14'd0, POL_SJF});
        for (int i = 0; i < TABLE_DEPTH + 3; i++)
            send_job(10'($urandom_range(0, 40)), 10'($urandom_range(1, 30)),
                     8'($urandom), i == TABLE_DEPTH + 2, 1'b0);
        drain();
        quiet_sink = 1'b0;
    endtask

    // Random loads with random register settings between them.
    task automatic test_random();
        int sent, n, r;
        logic [9:0] arr, run;
        sent = 0;
        while (sent < 385) begin
            r = $urandom_range(0, 9);
            if (r < 2) write_reg(CFG_POLICY, 16'($urandom_range(0, 3)));
            r = $urandom_range(0, 9);
            if (r == 0) write_reg(CFG_IDLE, 16'd0);
            else if (r == 1) write_reg(CFG_IDLE, 16'hFFFF);
            else if (r < 4) write_reg(CFG_IDLE, 16'($urandom));
            else if (r < 6) write_reg(CFG_IDLE, 16'($urandom_range(20, 200)));
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36)
                                              : $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 9);
                arr = (r < 7) ? 10'($urandom_range(0, 40)) : 10'($urandom);
                r = $urandom_range(0, 19);
                run = (r == 0) ? 10'd0 : (r < 14) ? 10'($urandom_range(1, 40))
                                                  : 10'($urandom);
                send_job(arr, run, 8'($urandom), i == n - 1);
            end
            sent += n;
            drain();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_POLICY;
        i_cfg_data <= '0;
        stall_left = 0;
        quiet_sink = 1'b0;
        jobs_loaded = 0;
        sched_policy = POL_FCFS;
        idle_limit = IDLE_LIMIT_RESET;
        fail_count = 0;
        cycle_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_policies();
        test_timeout_and_zero_run();
        test_table_full();
        test_random();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/njs_pkg.sv
sv/njs_div.sv
sv/njs_datapath.sv
sv/njs_ctrl.sv
sv/nonpreemptive_job_scheduler.sv
sim/tb_top.sv
